// ===== hw/rtl/pdc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the PWM divider and cycle calculator: constants, request and
// result layouts, stage carry types. No dependencies.
package pdc_pkg;

    localparam int unsigned NS_PER_S      = 1000000000;
    localparam int unsigned DIV_MAGIC     = 255 * 65537 + 2 * 65536 + 1;
    localparam int unsigned PRESC_DIV     = 65537;
    localparam int unsigned DIV_EXP_MAX   = 8;
    localparam int unsigned PRESC_MAX     = 255;

    localparam int NS_W   = 40;
    localparam int RATE_W = 32;
    localparam int QNS_W  = 11;   // ns / 1e9 for a 40-bit ns value
    localparam int CYC_W  = 43;   // floor(ns * rate / 1e9)

    // Pipelined divide by 1e9; dividend stays below 1e9 * 2^32.
    // Reciprocal floor(2^62 / 1e9) applied to dividend[61:30], then >> 32.
    localparam int CDIV_NW     = 62;
    localparam int CDIV_QW     = 32;
    localparam int CDIV_RW     = 30;
    localparam int CDIV_PW     = 65;
    localparam int CDIV_STAGES = 3;
    localparam logic [CDIV_NW-1:0] CDIV_DEN   = CDIV_NW'(NS_PER_S);
    localparam logic [32:0]        CDIV_RECIP = 33'd4611686018;
    localparam logic [31:0]        CDIV_D1    = 32'd1000000000;
    localparam logic [31:0]        CDIV_D2    = 32'd2000000000;
    localparam logic [31:0]        CDIV_D3    = 32'd3000000000;

    // Pipelined divide by a 9-bit value, bit-serial restoring
    localparam int SDIV_NW     = 44;
    localparam int SDIV_DW     = 9;
    localparam int SDIV_STEPS  = 4;
    localparam int SDIV_STAGES = SDIV_NW / SDIV_STEPS;

    localparam logic CFG_HOSC = 1'b0;
    localparam logic CFG_BUS  = 1'b1;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_DISABLED = 2'd1,
        ST_INVALID  = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0]      neighbor_div_m;
        logic            neighbor_use_bus;
        logic            neighbor_enabled;
        logic [NS_W-1:0] duty_ns;
        logic [NS_W-1:0] period_ns;
        logic            polarity_normal;
        logic            was_enabled;
        logic            enable_requested;
    } req_t;

    typedef struct packed {
        logic        toggle_enable;
        logic        active_high;
        logic [15:0] active_field;
        logic [15:0] entire_field;
        logic [7:0]  prescale_value;
        logic [3:0]  div_exponent;
        logic        use_bus_clock;
        logic        write_clock_cfg;
        status_t     status;
    } res_t;

    typedef struct packed {
        logic       en;
        logic       was;
        logic       pol;
        logic       nb_en;
        logic       nb_bus;
        logic [3:0] nb_div;
    } ctl_t;

    typedef struct packed {
        ctl_t       ctl;
        logic       use_bus;
        logic       bad;
        logic [3:0] div_m;
    } mid_t;

    typedef struct packed {
        mid_t       mid;
        logic [7:0] presc;
    } tail_t;

endpackage

// ===== hw/rtl/pdc_cdiv.sv =====
`timescale 1ns / 1ps
// Three-stage divide by 1e9: reciprocal multiply, back-multiply, correction.
// Uses pdc_pkg constants.
module pdc_cdiv (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [pdc_pkg::CDIV_NW-1:0]  dividend,
    output logic [pdc_pkg::CDIV_QW-1:0]  quotient,
    output logic [pdc_pkg::CDIV_RW-1:0]  remainder
);

    logic [pdc_pkg::CDIV_NW-1:0] num1_reg;
    logic [pdc_pkg::CDIV_PW-1:0] est1_reg;
    logic [pdc_pkg::CDIV_QW-1:0] quo2_reg;
    logic [pdc_pkg::CDIV_QW-1:0] rem2_reg;
    logic [pdc_pkg::CDIV_QW-1:0] quo_reg;
    logic [pdc_pkg::CDIV_RW-1:0] rem_reg;
    logic [pdc_pkg::CDIV_QW-1:0] quo_est;
    logic [pdc_pkg::CDIV_NW-1:0] rem_full;
    logic                        ge1;
    logic                        ge2;
    logic                        ge3;
    logic [1:0]                  fix;
    logic [pdc_pkg::CDIV_QW-1:0] rem_fix;

    // estimate is never high and at most three low, so the remainder is below 4e9
    assign quo_est  = est1_reg[2*pdc_pkg::CDIV_QW-1:pdc_pkg::CDIV_QW];
    assign rem_full = num1_reg - pdc_pkg::CDIV_NW'(quo_est) * pdc_pkg::CDIV_DEN;

    always_comb
    begin
        ge1 = rem2_reg >= pdc_pkg::CDIV_D1;
        ge2 = rem2_reg >= pdc_pkg::CDIV_D2;
        ge3 = rem2_reg >= pdc_pkg::CDIV_D3;
        fix = 2'(ge1) + 2'(ge2) + 2'(ge3);
        if (ge3)
            rem_fix = rem2_reg - pdc_pkg::CDIV_D3;
        else if (ge2)
            rem_fix = rem2_reg - pdc_pkg::CDIV_D2;
        else if (ge1)
            rem_fix = rem2_reg - pdc_pkg::CDIV_D1;
        else
            rem_fix = rem2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            est1_reg <= pdc_pkg::CDIV_PW'(dividend[pdc_pkg::CDIV_NW-1:
                                                   pdc_pkg::CDIV_NW-pdc_pkg::CDIV_QW])
                      * pdc_pkg::CDIV_PW'(pdc_pkg::CDIV_RECIP);
            num1_reg <= dividend;
            quo2_reg <= quo_est;
            rem2_reg <= rem_full[pdc_pkg::CDIV_QW-1:0];
            quo_reg  <= quo2_reg + pdc_pkg::CDIV_QW'(fix);
            rem_reg  <= rem_fix[pdc_pkg::CDIV_RW-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/pdc_sdiv.sv =====
`timescale 1ns / 1ps
// Pipelined bit-serial restoring divide of a 44-bit value by a nonzero
// 9-bit divisor, four bits per stage. Uses pdc_pkg constants.
module pdc_sdiv (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [pdc_pkg::SDIV_NW-1:0]  dividend,
    input  logic [pdc_pkg::SDIV_DW-1:0]  divisor,
    output logic [pdc_pkg::SDIV_NW-1:0]  quotient
);

    // dq holds the unconsumed dividend bits; quotient bits shift in below
    logic [pdc_pkg::SDIV_NW-1:0] dq_reg   [pdc_pkg::SDIV_STAGES];
    logic [pdc_pkg::SDIV_DW-1:0] rem_reg  [pdc_pkg::SDIV_STAGES];
    logic [pdc_pkg::SDIV_DW-1:0] den_reg  [pdc_pkg::SDIV_STAGES];
    logic [pdc_pkg::SDIV_NW-1:0] dq_next  [pdc_pkg::SDIV_STAGES];
    logic [pdc_pkg::SDIV_DW-1:0] rem_next [pdc_pkg::SDIV_STAGES];
    logic [pdc_pkg::SDIV_DW-1:0] den_next [pdc_pkg::SDIV_STAGES];
    logic [pdc_pkg::SDIV_NW-1:0] dq_cur;
    logic [pdc_pkg::SDIV_DW-1:0] rem_cur;
    logic [pdc_pkg::SDIV_DW-1:0] den_cur;
    logic [pdc_pkg::SDIV_DW:0]   trial;

    always_comb
    begin
        dq_cur  = '0;
        rem_cur = '0;
        den_cur = '0;
        trial   = '0;
        for (int s = 0; s < pdc_pkg::SDIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                dq_cur  = dividend;
                rem_cur = '0;
                den_cur = divisor;
            end
            else
            begin
                dq_cur  = dq_reg[s-1];
                rem_cur = rem_reg[s-1];
                den_cur = den_reg[s-1];
            end
            for (int j = 0; j < pdc_pkg::SDIV_STEPS; j++)
            begin
                trial  = {rem_cur, dq_cur[pdc_pkg::SDIV_NW-1]};
                dq_cur = {dq_cur[pdc_pkg::SDIV_NW-2:0], 1'b0};
                if (trial >= {1'b0, den_cur})
                begin
                    trial     = trial - {1'b0, den_cur};
                    dq_cur[0] = 1'b1;
                end
                rem_cur = trial[pdc_pkg::SDIV_DW-1:0];
            end
            dq_next[s]  = dq_cur;
            rem_next[s] = rem_cur;
            den_next[s] = den_cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < pdc_pkg::SDIV_STAGES; s++)
            begin
                dq_reg[s]  <= dq_next[s];
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_next[s];
            end
        end
    end

    assign quotient = dq_reg[pdc_pkg::SDIV_STAGES-1];

endmodule

// ===== hw/rtl/pwm_divider_and_cycle_calc.sv =====
`timescale 1ns / 1ps
// Top level of the PWM divider and cycle calculator.
// Depends on pdc_pkg, pdc_cdiv and pdc_sdiv.
//
// Usage:
//   s_* takes one channel request per transfer (period and duty in ns,
//   enable state, polarity, neighbor clock setup). m_* gives one result
//   per request: status, clock source and divider, prescaler, entire and
//   active fields, polarity and toggle bits.
//   cfg_we/cfg_index/cfg_wdata set the oscillator (index 0) and bus clock
//   (index 1) rates in Hz; write them only while no request is in flight.
// Timing:
//   One request per cycle sustained unless the output stalls. Path from input
//   transfer to m_tvalid: 3-stage divide by 1e9 of the ns values, multiply,
//   3-stage divide by 1e9 of the products, five sum/select/shift/prescale
//   stages, an 11-stage divide by the prescaler, then the output register.
// Reset: clears all valid bits and loads the default rates (24 MHz, 100 MHz).
// Stall: when m_tready is low with a result waiting, the whole pipeline
//   freezes and s_tready drops; nothing is lost or repeated.
module pwm_divider_and_cycle_calc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // enable_requested[0], was_enabled[1], polarity_normal[2],
    // period_ns[42:3], duty_ns[82:43], neighbor_enabled[83],
    // neighbor_use_bus[84], neighbor_div_m[88:85], zero[95:89]
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], write_clock_cfg[2], use_bus_clock[3], div_exponent[7:4],
    // prescale_value[15:8], entire_field[31:16], active_field[47:32],
    // active_high[48], toggle_enable[49], zero[55:50]
    output logic [55:0] m_tdata
);

    localparam int PIPE_DEPTH = 2 * pdc_pkg::CDIV_STAGES + pdc_pkg::SDIV_STAGES + 6;
    localparam int REQ_W = $bits(pdc_pkg::req_t);
    localparam int RES_W = $bits(pdc_pkg::res_t);
    localparam int CW    = pdc_pkg::CYC_W;

    logic [pdc_pkg::RATE_W-1:0] hosc_rate_reg;
    logic [pdc_pkg::RATE_W-1:0] bus_rate_reg;
    logic [PIPE_DEPTH-1:0]      vld_reg;
    logic                       out_valid_reg;
    logic                       adv;

    pdc_pkg::req_t req;
    pdc_pkg::ctl_t ctl_in;

    assign req = s_tdata[REQ_W-1:0];
    assign adv = !out_valid_reg || m_tready;
    assign s_tready = adv;

    assign ctl_in = '{en:     req.enable_requested,
                      was:    req.was_enabled,
                      pol:    req.polarity_normal,
                      nb_en:  req.neighbor_enabled,
                      nb_bus: req.neighbor_use_bus,
                      nb_div: req.neighbor_div_m};

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hosc_rate_reg <= 32'd24000000;
            bus_rate_reg  <= 32'd100000000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pdc_pkg::CFG_HOSC: hosc_rate_reg <= cfg_wdata;
                pdc_pkg::CFG_BUS:  bus_rate_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
            out_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    // ---- ns split into whole seconds and remainder ----
    logic [pdc_pkg::CDIV_QW-1:0] q_per, q_dut;
    logic [pdc_pkg::CDIV_RW-1:0] r_per, r_dut;
    pdc_pkg::ctl_t ctl1_reg [pdc_pkg::CDIV_STAGES];

    pdc_cdiv u_div_per (
        .clk       (clk),
        .adv       (adv),
        .dividend  (pdc_pkg::CDIV_NW'(req.period_ns)),
        .quotient  (q_per),
        .remainder (r_per)
    );

    pdc_cdiv u_div_dut (
        .clk       (clk),
        .adv       (adv),
        .dividend  (pdc_pkg::CDIV_NW'(req.duty_ns)),
        .quotient  (q_dut),
        .remainder (r_dut)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl1_reg[0] <= ctl_in;
            for (int i = 1; i < pdc_pkg::CDIV_STAGES; i++)
                ctl1_reg[i] <= ctl1_reg[i-1];
        end
    end

    // ---- multiply by both rates; index 0/1 period hosc/bus, 2/3 duty ----
    logic [pdc_pkg::CDIV_NW-1:0] prod_reg  [4];
    logic [pdc_pkg::CDIV_NW-1:0] prod_next [4];
    logic [CW-1:0]               qr_reg    [4];
    logic [CW-1:0]               qr_next   [4];
    pdc_pkg::ctl_t               ctl_m_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod_next[k] = pdc_pkg::CDIV_NW'((k < 2) ? r_per : r_dut)
                         * pdc_pkg::CDIV_NW'((k % 2 == 1) ? bus_rate_reg : hosc_rate_reg);
            qr_next[k]   = CW'((k < 2) ? q_per[pdc_pkg::QNS_W-1:0]
                                       : q_dut[pdc_pkg::QNS_W-1:0])
                         * CW'((k % 2 == 1) ? bus_rate_reg : hosc_rate_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= prod_next[k];
                qr_reg[k]   <= qr_next[k];
            end
            ctl_m_reg <= ctl1_reg[pdc_pkg::CDIV_STAGES-1];
        end
    end

    // ---- divide the remainder products by 1e9 ----
    logic [pdc_pkg::CDIV_QW-1:0] cq [4];
    logic [CW-1:0]               qr_dly  [pdc_pkg::CDIV_STAGES][4];
    pdc_pkg::ctl_t               ctl2_reg [pdc_pkg::CDIV_STAGES];

    for (genvar k = 0; k < 4; k++)
    begin : g_cyc
        pdc_cdiv u_div_cyc (
            .clk       (clk),
            .adv       (adv),
            .dividend  (prod_reg[k]),
            .quotient  (cq[k]),
            .remainder ()
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qr_dly[0]   <= qr_reg;
            ctl2_reg[0] <= ctl_m_reg;
            for (int i = 1; i < pdc_pkg::CDIV_STAGES; i++)
            begin
                qr_dly[i]   <= qr_dly[i-1];
                ctl2_reg[i] <= ctl2_reg[i-1];
            end
        end
    end

    // ---- sum into cycle counts ----
    logic [CW-1:0] cyc_reg [4];
    pdc_pkg::ctl_t ctl_e_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
                cyc_reg[k] <= qr_dly[pdc_pkg::CDIV_STAGES-1][k] + CW'(cq[k]);
            ctl_e_reg <= ctl2_reg[pdc_pkg::CDIV_STAGES-1];
        end
    end

    // ---- clock source selection ----
    logic [CW-1:0] val_f_reg, dval_f_reg, val_f_next, dval_f_next;
    pdc_pkg::mid_t mid_f_reg, mid_f_next;
    logic          hosc_ok;

    always_comb
    begin
        hosc_ok          = cyc_reg[0] > CW'(1);
        mid_f_next.ctl   = ctl_e_reg;
        mid_f_next.div_m = ctl_e_reg.nb_div;
        if (ctl_e_reg.nb_en)
        begin
            mid_f_next.use_bus = ctl_e_reg.nb_bus;
            mid_f_next.bad     = 1'b0;
        end
        else
        begin
            mid_f_next.use_bus = !hosc_ok;
            mid_f_next.bad     = !hosc_ok && (cyc_reg[1] <= CW'(1));
        end
        val_f_next  = mid_f_next.use_bus ? cyc_reg[1] : cyc_reg[0];
        dval_f_next = mid_f_next.use_bus ? cyc_reg[3] : cyc_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            val_f_reg  <= val_f_next;
            dval_f_reg <= dval_f_next;
            mid_f_reg  <= mid_f_next;
        end
    end

    // ---- divider exponent: fls(val / DIV_MAGIC) via thermometer compare ----
    logic [pdc_pkg::DIV_EXP_MAX:0] mag_ge;
    logic [3:0]                    auto_m;
    logic [CW-1:0]                 val_g_reg, dval_g_reg;
    pdc_pkg::mid_t                 mid_g_reg, mid_g_next;

    always_comb
    begin
        auto_m = '0;
        for (int n = 0; n <= pdc_pkg::DIV_EXP_MAX; n++)
            mag_ge[n] = val_f_reg >= (CW'(pdc_pkg::DIV_MAGIC) << n);
        for (int n = 0; n < pdc_pkg::DIV_EXP_MAX; n++)
            auto_m = auto_m + 4'(mag_ge[n]);
        mid_g_next = mid_f_reg;
        if (!mid_f_reg.ctl.nb_en)
        begin
            mid_g_next.div_m = auto_m;
            mid_g_next.bad   = mid_f_reg.bad || mag_ge[pdc_pkg::DIV_EXP_MAX];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            val_g_reg  <= val_f_reg;
            dval_g_reg <= dval_f_reg;
            mid_g_reg  <= mid_g_next;
        end
    end

    // ---- apply divider ----
    logic [CW-1:0] ent0_h_reg, aval_h_reg;
    pdc_pkg::mid_t mid_h_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent0_h_reg <= val_g_reg >> mid_g_reg.div_m;
            aval_h_reg <= dval_g_reg >> mid_g_reg.div_m;
            mid_h_reg  <= mid_g_reg;
        end
    end

    // ---- prescaler: min(ent0 / 65537, 255) ----
    // Below the cap, ent0 >> 16 is the quotient or one too high.
    localparam logic [CW-1:0] PRESC_LIM = CW'(pdc_pkg::PRESC_DIV * (pdc_pkg::PRESC_MAX + 1));
    logic [8:0]    q_hi, q_fix;
    logic [7:0]    presc_next;
    logic [CW-1:0] ent0_i_reg, aval_i_reg;
    pdc_pkg::tail_t tail_i_reg;

    always_comb
    begin
        q_hi  = 9'(ent0_h_reg >> 16);
        q_fix = (ent0_h_reg[15:0] < 16'(q_hi)) ? q_hi - 9'd1 : q_hi;
        if (ent0_h_reg >= PRESC_LIM)
            presc_next = 8'(pdc_pkg::PRESC_MAX);
        else
            presc_next = q_fix[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent0_i_reg       <= ent0_h_reg;
            aval_i_reg       <= aval_h_reg;
            tail_i_reg.mid   <= mid_h_reg;
            tail_i_reg.presc <= presc_next;
        end
    end

    // ---- divide by prescaler + 1 ----
    logic [pdc_pkg::SDIV_NW-1:0] ent_q, act_q;
    logic [pdc_pkg::SDIV_DW-1:0] presc_den;
    pdc_pkg::tail_t              tail_dly [pdc_pkg::SDIV_STAGES];

    assign presc_den = pdc_pkg::SDIV_DW'(tail_i_reg.presc) + pdc_pkg::SDIV_DW'(1);

    pdc_sdiv u_div_ent (
        .clk      (clk),
        .adv      (adv),
        .dividend (pdc_pkg::SDIV_NW'(ent0_i_reg)),
        .divisor  (presc_den),
        .quotient (ent_q)
    );

    pdc_sdiv u_div_act (
        .clk      (clk),
        .adv      (adv),
        .dividend (pdc_pkg::SDIV_NW'(aval_i_reg)),
        .divisor  (presc_den),
        .quotient (act_q)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_dly[0] <= tail_i_reg;
            for (int i = 1; i < pdc_pkg::SDIV_STAGES; i++)
                tail_dly[i] <= tail_dly[i-1];
        end
    end

    // ---- result ----
    pdc_pkg::tail_t tl;
    pdc_pkg::res_t  res_reg, res_next;

    assign tl = tail_dly[pdc_pkg::SDIV_STAGES-1];

    always_comb
    begin
        res_next = '0;
        if (!tl.mid.ctl.en)
        begin
            res_next.status        = pdc_pkg::ST_DISABLED;
            res_next.toggle_enable = tl.mid.ctl.was;
        end
        else if (tl.mid.bad || (ent_q == '0))
        begin
            res_next.status = pdc_pkg::ST_INVALID;
        end
        else
        begin
            res_next.status          = pdc_pkg::ST_VALID;
            res_next.write_clock_cfg = !tl.mid.ctl.nb_en;
            res_next.use_bus_clock   = tl.mid.use_bus;
            res_next.div_exponent    = tl.mid.div_m;
            res_next.prescale_value  = tl.presc;
            res_next.entire_field    = ent_q[15:0] - 16'd1;
            res_next.active_field    = act_q[15:0];
            res_next.active_high     = tl.mid.ctl.pol;
            res_next.toggle_enable   = !tl.mid.ctl.was;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(56 - RES_W)'(0), res_reg};

    // ---- assertions ----
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_disabled_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.status == pdc_pkg::ST_DISABLED)
        |-> !res_reg.write_clock_cfg && (res_reg.prescale_value == 8'd0)
            && (res_reg.entire_field == 16'd0) && (res_reg.active_field == 16'd0))
        else $error("disabled result carries nonzero fields");

    a_auto_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.write_clock_cfg
        |-> (res_reg.div_exponent <= 4'(pdc_pkg::DIV_EXP_MAX)))
        else $error("selected divider exponent out of range");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");

endmodule
